// ===== rtl/cos_pkg.sv =====
// ----------------------------------------------------------------------------
// cos_pkg: charger output supervisor shared types
// Mode codes, register indexes, configuration, sample and result words.
// ----------------------------------------------------------------------------
package cos_pkg;

   localparam int ADC_WIDTH = 10;
   localparam int MS_WIDTH  = 16;
   localparam int IDX_WIDTH = 3;

   localparam logic [ADC_WIDTH-1:0] ADC_MAX = '1;

   typedef enum logic [1:0] {
      MODE_CHECK   = 2'd0,
      MODE_SETTLE  = 2'd1,
      MODE_MONITOR = 2'd2,
      MODE_FAULT   = 2'd3
   } mode_type;

   typedef enum logic [IDX_WIDTH-1:0] {
      REG_WINDOW_MS      = 3'd0,
      REG_SETTLE_MS      = 3'd1,
      REG_BLINK_MS       = 3'd2,
      REG_VOUT_THRESHOLD = 3'd3,
      REG_BAT_THRESHOLD  = 3'd4
   } reg_index_type;

   localparam logic [MS_WIDTH-1:0]  WINDOW_MS_RESET      = 16'd1000;
   localparam logic [MS_WIDTH-1:0]  SETTLE_MS_RESET      = 16'd500;
   localparam logic [MS_WIDTH-1:0]  BLINK_MS_RESET       = 16'd200;
   localparam logic [ADC_WIDTH-1:0] VOUT_THRESHOLD_RESET = 10'd925;
   localparam logic [ADC_WIDTH-1:0] BAT_THRESHOLD_RESET  = 10'd0;

   typedef struct packed {
      logic [MS_WIDTH-1:0]  window_ms;
      logic [MS_WIDTH-1:0]  settle_ms;
      logic [MS_WIDTH-1:0]  blink_ms;
      logic [ADC_WIDTH-1:0] vout_threshold;
      logic [ADC_WIDTH-1:0] bat_threshold;
   } cfg_type;

   typedef struct packed {
      logic [ADC_WIDTH-1:0] bat_one_sample;
      logic [ADC_WIDTH-1:0] bat_two_sample;
      logic [ADC_WIDTH-1:0] out_sample;
      logic                 ms_tick;
   } sample_type;

   typedef struct packed {
      logic     switch_on;
      logic     led_on;
      logic     fault;
      mode_type mode;
   } result_type;

endpackage

// ===== rtl/cos_if.sv =====
// ----------------------------------------------------------------------------
// cos_if: charger output supervisor channels
// Sample request, status response and register write channels.
// ----------------------------------------------------------------------------
interface cos_req_if;
   logic       valid;
   logic       ready;
   logic [9:0] bat_one_sample;
   logic [9:0] bat_two_sample;
   logic [9:0] out_sample;
   logic       ms_tick;

   modport source (output valid, output bat_one_sample, output bat_two_sample,
                   output out_sample, output ms_tick, input ready);
   modport sink   (input valid, input bat_one_sample, input bat_two_sample,
                   input out_sample, input ms_tick, output ready);
endinterface

interface cos_rsp_if;
   logic       valid;
   logic       ready;
   logic       switch_on;
   logic       led_on;
   logic       fault;
   logic [1:0] mode;

   modport source (output valid, output switch_on, output led_on, output fault,
                   output mode, input ready);
   modport sink   (input valid, input switch_on, input led_on, input fault,
                   input mode, output ready);
endinterface

interface cos_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/cos_csr.sv =====
// ----------------------------------------------------------------------------
// cos_csr: configuration registers
// Holds window, settle and blink times and the two thresholds.
// ----------------------------------------------------------------------------
module cos_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [cos_pkg::IDX_WIDTH-1:0]       wr_index,
   input  logic [cos_pkg::MS_WIDTH-1:0]        wr_data,
   output cos_pkg::cfg_type                    cfg
);
   import cos_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index_type'(wr_index))
            REG_WINDOW_MS:      cfg_in.window_ms      = wr_data;
            REG_SETTLE_MS:      cfg_in.settle_ms      = wr_data;
            REG_BLINK_MS:       cfg_in.blink_ms       = wr_data;
            REG_VOUT_THRESHOLD: cfg_in.vout_threshold = wr_data[ADC_WIDTH-1:0];
            REG_BAT_THRESHOLD:  cfg_in.bat_threshold  = wr_data[ADC_WIDTH-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_ms      <= WINDOW_MS_RESET;
         cfg_ff.settle_ms      <= SETTLE_MS_RESET;
         cfg_ff.blink_ms       <= BLINK_MS_RESET;
         cfg_ff.vout_threshold <= VOUT_THRESHOLD_RESET;
         cfg_ff.bat_threshold  <= BAT_THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/cos_core.sv =====
// ----------------------------------------------------------------------------
// cos_core: supervisor state update
// Battery window check, settle wait, output group minimum and fault blink.
// ----------------------------------------------------------------------------
module cos_core #(
   parameter int GROUP_SAMPLES = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  cos_pkg::cfg_type    cfg,
   input  cos_pkg::sample_type sample,
   output cos_pkg::result_type result_in
);
   import cos_pkg::*;

   localparam int GCW = $clog2(GROUP_SAMPLES + 1);
   localparam logic [GCW-1:0] GROUP_LAST = GCW'(GROUP_SAMPLES);

   mode_type             mode_ff,  mode_in;
   logic [MS_WIDTH-1:0]  ms_ff,    ms_in;
   logic [ADC_WIDTH-1:0] bat_one_max_ff, bat_one_max_in;
   logic [ADC_WIDTH-1:0] bat_two_max_ff, bat_two_max_in;
   logic [ADC_WIDTH-1:0] out_min_ff, out_min_in;
   logic [GCW-1:0]       group_ff, group_in;
   logic                 led_ff,   led_in;

   logic [MS_WIDTH-1:0]  ms_ticked;
   logic [GCW-1:0]       group_inc;
   logic                 present;

   always_comb begin
      // saturate at the top of the counter
      ms_ticked = (sample.ms_tick && (ms_ff != '1)) ? ms_ff + 1'b1 : ms_ff;
      group_inc = group_ff + 1'b1;

      mode_in        = mode_ff;
      ms_in          = ms_ff;
      bat_one_max_in = bat_one_max_ff;
      bat_two_max_in = bat_two_max_ff;
      out_min_in     = out_min_ff;
      group_in       = group_ff;
      led_in         = led_ff;
      present        = 1'b0;

      case (mode_ff)
         MODE_CHECK: begin
            if (sample.bat_one_sample > bat_one_max_ff) bat_one_max_in = sample.bat_one_sample;
            if (sample.bat_two_sample > bat_two_max_ff) bat_two_max_in = sample.bat_two_sample;
            ms_in = ms_ticked;
            if (ms_ticked >= cfg.window_ms) begin
               present = (bat_one_max_in > cfg.bat_threshold) ||
                         (bat_two_max_in > cfg.bat_threshold);
               ms_in          = '0;
               bat_one_max_in = '0;
               bat_two_max_in = '0;
               if (!present) mode_in = MODE_SETTLE;
            end
         end
         MODE_SETTLE: begin
            ms_in = ms_ticked;
            if (ms_ticked >= cfg.settle_ms) begin
               mode_in    = MODE_MONITOR;
               led_in     = 1'b1;
               ms_in      = '0;
               out_min_in = ADC_MAX;
               group_in   = '0;
            end
         end
         MODE_MONITOR: begin
            if (sample.out_sample < out_min_ff) out_min_in = sample.out_sample;
            group_in = group_inc;
            if (group_inc >= GROUP_LAST) begin
               if (out_min_in <= cfg.vout_threshold) begin
                  mode_in = MODE_FAULT;
                  ms_in   = '0;
               end
               out_min_in = ADC_MAX;
               group_in   = '0;
            end
         end
         default: begin
            ms_in = ms_ticked;
            if (ms_ticked >= cfg.blink_ms) begin
               led_in = ~led_ff;
               ms_in  = '0;
            end
         end
      endcase

      result_in.switch_on = (mode_in == MODE_SETTLE) || (mode_in == MODE_MONITOR);
      result_in.led_on    = led_in;
      result_in.fault     = (mode_in == MODE_FAULT);
      result_in.mode      = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_CHECK;
         ms_ff          <= '0;
         bat_one_max_ff <= '0;
         bat_two_max_ff <= '0;
         out_min_ff     <= ADC_MAX;
         group_ff       <= '0;
         led_ff         <= 1'b0;
      end else if (advance) begin
         mode_ff        <= mode_in;
         ms_ff          <= ms_in;
         bat_one_max_ff <= bat_one_max_in;
         bat_two_max_ff <= bat_two_max_in;
         out_min_ff     <= out_min_in;
         group_ff       <= group_in;
         led_ff         <= led_in;
      end
   end

   // fault holds until reset
   a_fault_latched: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_FAULT |=> mode_ff == MODE_FAULT)
      else $error("fault mode left without reset");

   a_group_range: assert property (@(posedge clock) disable iff (reset)
      group_ff < GROUP_LAST)
      else $error("group counter past group size");

   a_led_dark_early: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_CHECK || mode_ff == MODE_SETTLE) |-> !led_ff)
      else $error("LED lit before monitoring");

   a_monitor_entry: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_MONITOR && $past(mode_ff) != MODE_MONITOR) |->
      (led_ff && group_ff == '0 && out_min_ff == ADC_MAX))
      else $error("monitoring entered without clean group state");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(mode_ff) && $stable(ms_ff) && $stable(led_ff))
      else $error("state moved without a word");

endmodule

// ===== rtl/charger_output_supervisor.sv =====
// A request word is accepted into the input register, passes the state update and is
// written into the response register, which drives the response port.
// Throughput: one word per cycle while responses are taken; the response register frees
// the input side, so a new word is taken whenever the result stage is empty or being drained.
// Reset (synchronous): mode checking, counters and maxima zero, group minimum
// 1023, LED off, registers at their default values, both stages empty.
// ----------------------------------------------------------------------------
// charger_output_supervisor: top level
// Input register, supervisor state update and result register.
// ----------------------------------------------------------------------------
module charger_output_supervisor #(
   parameter int GROUP_SAMPLES = 4
) (
   input logic       clock,
   input logic       reset,
   cos_req_if.sink   req_port,
   cos_rsp_if.source rsp_port,
   cos_csr_if.sink   csr_port
);
   import cos_pkg::*;

   cfg_type    cfg;
   sample_type req_word_ff;
   logic       req_vld_ff, req_vld_in;
   result_type rsp_word_ff, rsp_word_in;
   logic       rsp_vld_ff, rsp_vld_in;
   logic       advance;

   assign advance        = req_vld_ff && (!rsp_vld_ff || rsp_port.ready);
   assign req_port.ready = !req_vld_ff || advance;
   assign csr_port.ready = 1'b1;

   assign req_vld_in = req_port.valid || (req_vld_ff && !advance);
   assign rsp_vld_in = advance || (rsp_vld_ff && !rsp_port.ready);

   cos_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_port.valid),
      .wr_index (csr_port.index),
      .wr_data  (csr_port.data),
      .cfg      (cfg)
   );

   cos_core #(
      .GROUP_SAMPLES (GROUP_SAMPLES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg),
      .sample    (req_word_ff),
      .result_in (rsp_word_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (req_port.ready) req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_port.valid && req_port.ready) begin
         req_word_ff.bat_one_sample <= req_port.bat_one_sample;
         req_word_ff.bat_two_sample <= req_port.bat_two_sample;
         req_word_ff.out_sample     <= req_port.out_sample;
         req_word_ff.ms_tick        <= req_port.ms_tick;
      end
      if (advance) rsp_word_ff <= rsp_word_in;
   end

   assign rsp_port.valid     = rsp_vld_ff;
   assign rsp_port.switch_on = rsp_word_ff.switch_on;
   assign rsp_port.led_on    = rsp_word_ff.led_on;
   assign rsp_port.fault     = rsp_word_ff.fault;
   assign rsp_port.mode      = rsp_word_ff.mode;

endmodule
